### hw/rtl/pid_aw_pkg.sv
package pid_aw_pkg;

	// Sample and register widths
	localparam int DATA_W      = 32;
	localparam int DT_W        = 16;
	localparam int ACC_W       = 48;
	localparam int UNC_W       = 34;

	// Fixed point scaling
	localparam int FRAC_BITS   = 16;
	localparam int DERIV_SHIFT = 16;
	localparam int KAW_GAIN    = 13107;

	// Product unit: |a| is 32 bits, |b| is 48 bits, split in two halves
	localparam int MAG_A_W     = DATA_W;
	localparam int MAG_B_W     = ACC_W;
	localparam int HALF_W      = MAG_B_W / 2;
	localparam int PPROD_W     = MAG_A_W + HALF_W;
	localparam int PROD_W      = MAG_A_W + MAG_B_W;

	// Derivative divider, several quotient bits per cycle
	localparam int DIV_NUM_W   = DATA_W + DERIV_SHIFT;
	localparam int DIV_RADIX   = 4;
	localparam int DIV_ITER    = DIV_NUM_W / DIV_RADIX;
	localparam int DIV_CNT_W   = $clog2(DIV_ITER + 1);

	// Configuration register map
	localparam int CFG_IDX_W   = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P,
		REG_GAIN_I,
		REG_GAIN_D,
		REG_GAIN_FF,
		REG_OUT_LOW,
		REG_OUT_HIGH,
		REG_ERR_LOW,
		REG_ERR_HIGH
	} cfg_reg_t;

	// Products formed by the shared multiplier
	typedef enum logic [2:0] {
		MOP_ED,   // error times time step
		MOP_AW,   // back-calculation gain times clip excess
		MOP_P,    // proportional term
		MOP_I,    // integral term
		MOP_F,    // feedforward term
		MOP_D     // derivative term
	} mul_op_t;

	typedef struct packed {
		logic    load_in;
		logic    calc_err;
		logic    prep;
		logic    mul_load;
		logic    mul_lo;
		logic    mul_hi;
		logic    mul_add;
		logic    mul_fin;
		mul_op_t mul_op;
		logic    incr;
		logic    integ;
		logic    sum1;
		logic    sum2;
		logic    out_load;
	} pid_aw_cmd_t;

	typedef struct packed {
		logic div_busy;
	} pid_aw_sts_t;

endpackage

### hw/rtl/pid_aw_if.sv
interface pid_aw_in_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [pid_aw_pkg::DATA_W-1:0]   target;
	logic signed [pid_aw_pkg::DATA_W-1:0]   measured;
	logic        [pid_aw_pkg::DT_W-1:0]     step_time;
	logic signed [pid_aw_pkg::DATA_W-1:0]   expected;
	logic                                   ff_enable;
	logic                                   mode;

	modport source (
		output valid, target, measured, step_time, expected, ff_enable, mode,
		input  ready
	);
	modport sink (
		input  valid, target, measured, step_time, expected, ff_enable, mode,
		output ready
	);
endinterface

interface pid_aw_out_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [pid_aw_pkg::DATA_W-1:0]   drive;

	modport source (output valid, drive, input ready);
	modport sink (input valid, drive, output ready);
endinterface

interface pid_aw_cfg_if;
	logic                                   valid;
	logic                                   ready;
	logic        [pid_aw_pkg::CFG_IDX_W-1:0] index;
	logic        [pid_aw_pkg::DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/pid_antiwindup_controller.sv
// channel  dir  handshake    beat carries
// samp     in   valid/ready  target, measured, step_time, expected, ff_enable, mode
// res      out  valid/ready  drive
// cfg      in   valid/ready  index, data (always ready, one register per beat)
//
// The sequencer works on one sample at a time: a new sample beat is accepted only once the
// previous result has been loaded and the sequencer is back in idle. The rate is set by the
// shared 32x24 multiplier, which forms six products in turn. The derivative divider
// (four quotient bits per step) runs alongside the first products. Reset zeroes the gains
// and loop state and opens the output limits and error window to the full range.
// A stalled result holds in the output register; only the final load step waits.
module pid_antiwindup_controller (
	input  logic          clk,
	input  logic          arst_n,
	pid_aw_in_if.sink     samp,
	pid_aw_out_if.source  res,
	pid_aw_cfg_if.sink    cfg
);
	import pid_aw_pkg::*;

	pid_aw_cmd_t cmd;
	pid_aw_sts_t sts;

	assign cfg.ready = 1'b1;

	pid_aw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samp.valid),
		.in_ready  (samp.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	pid_aw_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data),
		.target    (samp.target),
		.measured  (samp.measured),
		.step_time (samp.step_time),
		.expected  (samp.expected),
		.ff_enable (samp.ff_enable),
		.mode      (samp.mode),
		.drive     (res.drive)
	);

endmodule

### hw/rtl/pid_aw_div.sv
module pid_aw_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [pid_aw_pkg::DIV_NUM_W-1:0]   num,
	input  logic [pid_aw_pkg::DT_W-1:0]        den,
	output logic                               busy,
	output logic [pid_aw_pkg::DIV_NUM_W-1:0]   quot
);
	import pid_aw_pkg::*;

	logic [DT_W-1:0]      rem_q;
	logic [DT_W-1:0]      den_q;
	logic [DIV_NUM_W-1:0] work_q;
	logic [DIV_CNT_W-1:0] cnt_q;

	logic [DT_W-1:0]      rem_n;
	logic [DIV_NUM_W-1:0] work_n;
	logic [DT_W:0]        trial;

	assign busy = (cnt_q != '0);
	assign quot = work_q;

	// Restoring steps: numerator bits leave the top, quotient bits enter the bottom
	always_comb begin
		rem_n  = rem_q;
		work_n = work_q;
		trial  = '0;
		for (int k = 0; k < DIV_RADIX; k++) begin
			trial  = {rem_n, work_n[DIV_NUM_W-1]};
			work_n = {work_n[DIV_NUM_W-2:0], 1'b0};
			if (trial >= {1'b0, den_q}) begin
				rem_n     = DT_W'(trial - {1'b0, den_q});
				work_n[0] = 1'b1;
			end else begin
				rem_n = trial[DT_W-1:0];
			end
		end
	end

	// Count iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= DIV_CNT_W'(DIV_ITER);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// Load operands, then advance the partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			work_q <= num;
			den_q  <= den;
		end else if (busy) begin
			rem_q  <= rem_n;
			work_q <= work_n;
		end
	end

`ifndef SYNTHESIS
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy)
		else $error("divider restarted while busy");
`endif

endmodule

### hw/rtl/pid_aw_ctrl.sv
module pid_aw_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	output logic                     out_valid,
	input  logic                     out_ready,
	output pid_aw_pkg::pid_aw_cmd_t  cmd,
	input  pid_aw_pkg::pid_aw_sts_t  sts
);
	import pid_aw_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ERR,
		S_PREP,
		S_MUL,
		S_INCR,
		S_INTEG,
		S_SUM1,
		S_SUM2,
		S_OUT
	} state_t;

	typedef enum logic [2:0] {
		PH_LOAD,
		PH_LO,
		PH_HI,
		PH_ADD,
		PH_FIN
	} phase_t;

	state_t  state_q;
	phase_t  ph_q;
	mul_op_t op_q;
	logic    out_valid_q;

	logic    mul_wait;
	logic    out_free;

	// Derivative product waits for the quotient
	assign mul_wait  = (op_q == MOP_D) && sts.div_busy;
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Decode datapath commands
	always_comb begin
		cmd          = '0;
		cmd.mul_op   = op_q;
		cmd.load_in  = in_valid && (state_q == S_IDLE);
		cmd.calc_err = (state_q == S_ERR);
		cmd.prep     = (state_q == S_PREP);
		cmd.incr     = (state_q == S_INCR);
		cmd.integ    = (state_q == S_INTEG);
		cmd.sum1     = (state_q == S_SUM1);
		cmd.sum2     = (state_q == S_SUM2);
		cmd.out_load = (state_q == S_OUT) && out_free;
		if (state_q == S_MUL) begin
			case (ph_q)
				PH_LOAD: cmd.mul_load = !mul_wait;
				PH_LO:   cmd.mul_lo   = 1'b1;
				PH_HI:   cmd.mul_hi   = 1'b1;
				PH_ADD:  cmd.mul_add  = 1'b1;
				PH_FIN:  cmd.mul_fin  = 1'b1;
				default: cmd.mul_fin  = 1'b0;
			endcase
		end
	end

	// Sequence one sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ph_q        <= PH_LOAD;
			op_q        <= MOP_ED;
			out_valid_q <= 1'b0;
		end else begin
			// Raise the result beat on the final step, drop it once taken
			if ((state_q == S_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_ERR;
					end
				end
				S_ERR: begin
					state_q <= S_PREP;
				end
				S_PREP: begin
					state_q <= S_MUL;
					op_q    <= MOP_ED;
					ph_q    <= PH_LOAD;
				end
				S_MUL: begin
					case (ph_q)
						PH_LOAD: begin
							if (!mul_wait) begin
								ph_q <= PH_LO;
							end
						end
						PH_LO:  ph_q <= PH_HI;
						PH_HI:  ph_q <= PH_ADD;
						PH_ADD: ph_q <= PH_FIN;
						PH_FIN: begin
							ph_q <= PH_LOAD;
							case (op_q)
								MOP_ED:  op_q    <= MOP_AW;
								MOP_AW:  state_q <= S_INCR;
								MOP_P:   op_q    <= MOP_I;
								MOP_I:   op_q    <= MOP_F;
								MOP_F:   op_q    <= MOP_D;
								MOP_D:   state_q <= S_SUM1;
								default: state_q <= S_SUM1;
							endcase
						end
						default: ph_q <= PH_LOAD;
					endcase
				end
				S_INCR: begin
					state_q <= S_INTEG;
				end
				S_INTEG: begin
					state_q <= S_MUL;
					op_q    <= MOP_P;
				end
				S_SUM1: begin
					state_q <= S_SUM2;
				end
				S_SUM2: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_out_from_final: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_OUT))
		else $error("result beat raised outside the final step");

	a_quot_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.mul_load && (cmd.mul_op == MOP_D)) |-> !sts.div_busy)
		else $error("derivative product loaded before the quotient");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_in |=> (state_q == S_ERR) && !cmd.load_in)
		else $error("sample beat did not start the sequence");
`endif

endmodule

### hw/rtl/pid_aw_dp.sv
module pid_aw_dp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  pid_aw_pkg::pid_aw_cmd_t                cmd,
	output pid_aw_pkg::pid_aw_sts_t                sts,
	input  logic                                   cfg_we,
	input  logic        [pid_aw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic        [pid_aw_pkg::DATA_W-1:0]   cfg_data,
	input  logic signed [pid_aw_pkg::DATA_W-1:0]   target,
	input  logic signed [pid_aw_pkg::DATA_W-1:0]   measured,
	input  logic        [pid_aw_pkg::DT_W-1:0]     step_time,
	input  logic signed [pid_aw_pkg::DATA_W-1:0]   expected,
	input  logic                                   ff_enable,
	input  logic                                   mode,
	output logic signed [pid_aw_pkg::DATA_W-1:0]   drive
);
	import pid_aw_pkg::*;

	localparam logic signed [DATA_W-1:0] S32_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] S32_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [ACC_W-1:0]  ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0]  ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic signed [UNC_W-1:0]  UNC_MAX = {1'b0, {(UNC_W-1){1'b1}}};
	localparam logic signed [UNC_W-1:0]  UNC_MIN = {1'b1, {(UNC_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] KAW_A   = DATA_W'(KAW_GAIN);
	localparam int R_W = PROD_W - FRAC_BITS;

	// Configuration
	logic signed [DATA_W-1:0]  gain_p_q, gain_i_q, gain_d_q, gain_ff_q;
	logic signed [DATA_W-1:0]  out_low_q, out_high_q, err_low_q, err_high_q;

	// Sample
	logic signed [DATA_W-1:0]  tgt_q, meas_q, exp_q;
	logic        [DT_W-1:0]    dt_q;
	logic                      ff_q, mode_q;

	// Loop state
	logic signed [DATA_W-1:0]  prev_err_q;
	logic signed [ACC_W-1:0]   integ_q;
	logic signed [UNC_W-1:0]   prevu_q;

	// Per-sample working values
	logic signed [DATA_W-1:0]  err_q;
	logic signed [DATA_W:0]    ediff_q;
	logic signed [UNC_W:0]     clipdiff_q;
	logic                      above_q, below_q, beta_q, gamma_q, dneg_q;

	// Product unit
	logic [MAG_A_W-1:0]        amag_q;
	logic [MAG_B_W-1:0]        bmag_q;
	logic                      neg_q;
	logic [PPROD_W-1:0]        plo_q, phi_q;
	logic [PROD_W-1:0]         prod_q;

	// Terms and sums
	logic signed [ACC_W-1:0]   incr1_q, incr2_q, p_q, i_q, f_q, d_q;
	logic signed [ACC_W:0]     incr_q, s1_q, s2_q;
	logic signed [DATA_W-1:0]  drive_q;

	// Combinational
	logic signed [DATA_W:0]    err_wide, ediff_wide, ddiff;
	logic signed [DATA_W-1:0]  err_sat;
	logic signed [UNC_W-1:0]   lo_ext, hi_ext, clip_lo, clip_v;
	logic [DATA_W-1:0]         dmag;
	logic                      div_busy;
	logic [DIV_NUM_W-1:0]      quot;
	logic signed [DATA_W-1:0]  a_sel;
	logic signed [ACC_W-1:0]   b_sel;
	logic [MAG_A_W-1:0]        a_mag;
	logic [MAG_B_W-1:0]        b_mag;
	logic                      b_neg;
	logic [HALF_W-1:0]         mb;
	logic [PPROD_W-1:0]        mprod;
	logic [R_W-1:0]            rq;
	logic                      r_ovf;
	logic signed [ACC_W-1:0]   mres;
	logic signed [ACC_W+1:0]   isum;
	logic signed [ACC_W+1:0]   tot;

	assign sts.div_busy = div_busy;
	assign drive        = drive_q;

	// Error, feedforward difference and clip of the held unclipped output
	always_comb begin
		err_wide   = {tgt_q[DATA_W-1], tgt_q} - {meas_q[DATA_W-1], meas_q};
		ediff_wide = {exp_q[DATA_W-1], exp_q} - {meas_q[DATA_W-1], meas_q};
		if (err_wide[DATA_W] != err_wide[DATA_W-1]) begin
			err_sat = err_wide[DATA_W] ? S32_MIN : S32_MAX;
		end else begin
			err_sat = err_wide[DATA_W-1:0];
		end
		lo_ext  = {{(UNC_W-DATA_W){out_low_q[DATA_W-1]}}, out_low_q};
		hi_ext  = {{(UNC_W-DATA_W){out_high_q[DATA_W-1]}}, out_high_q};
		clip_lo = (prevu_q < lo_ext) ? lo_ext : prevu_q;
		clip_v  = (clip_lo > hi_ext) ? hi_ext : clip_lo;
	end

	// Derivative difference magnitude
	always_comb begin
		ddiff = {err_q[DATA_W-1], err_q} - {prev_err_q[DATA_W-1], prev_err_q};
		dmag  = ddiff[DATA_W] ? DATA_W'(-ddiff) : ddiff[DATA_W-1:0];
	end

	pid_aw_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.prep),
		.num    ({dmag, {DERIV_SHIFT{1'b0}}}),
		.den    (dt_q),
		.busy   (div_busy),
		.quot   (quot)
	);

	// Select product operands as sign and magnitude
	always_comb begin
		a_sel = '0;
		b_sel = '0;
		case (cmd.mul_op)
			MOP_ED: begin
				a_sel = err_q;
				b_sel = {{(ACC_W-DT_W){1'b0}}, dt_q};
			end
			MOP_AW: begin
				a_sel = KAW_A;
				b_sel = {{(ACC_W-UNC_W-1){clipdiff_q[UNC_W]}}, clipdiff_q};
			end
			MOP_P: begin
				a_sel = gain_p_q;
				b_sel = {{(ACC_W-DATA_W){err_q[DATA_W-1]}}, err_q};
			end
			MOP_I: begin
				a_sel = gain_i_q;
				b_sel = integ_q;
			end
			MOP_F: begin
				a_sel = gain_ff_q;
				b_sel = {{(ACC_W-DATA_W-1){ediff_q[DATA_W]}}, ediff_q};
			end
			MOP_D: begin
				a_sel = gain_d_q;
			end
			default: begin
				a_sel = '0;
			end
		endcase
		a_mag = a_sel[DATA_W-1] ? MAG_A_W'(-a_sel) : a_sel;
		if (cmd.mul_op == MOP_D) begin
			b_mag = (dt_q == '0) ? '0 : MAG_B_W'(quot);
			b_neg = dneg_q;
		end else begin
			b_mag = b_sel[ACC_W-1] ? MAG_B_W'(-b_sel) : b_sel;
			b_neg = b_sel[ACC_W-1];
		end
	end

	// One shared multiplier for both halves of the wide operand
	assign mb    = cmd.mul_hi ? bmag_q[MAG_B_W-1:HALF_W] : bmag_q[HALF_W-1:0];
	assign mprod = PPROD_W'(amag_q) * PPROD_W'(mb);

	// Scale, saturate and restore the sign
	always_comb begin
		rq    = prod_q[PROD_W-1:FRAC_BITS];
		r_ovf = |rq[R_W-1:ACC_W-1];
		if (r_ovf) begin
			mres = neg_q ? ACC_MIN : ACC_MAX;
		end else begin
			mres = neg_q ? ACC_W'(-rq[ACC_W-1:0]) : rq[ACC_W-1:0];
		end
	end

	// Integrator and output sums
	always_comb begin
		isum = {{2{integ_q[ACC_W-1]}}, integ_q} + {incr_q[ACC_W], incr_q};
		tot  = {s1_q[ACC_W], s1_q} + {s2_q[ACC_W], s2_q};
	end

	// Hold configuration and loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q   <= '0;
			gain_i_q   <= '0;
			gain_d_q   <= '0;
			gain_ff_q  <= '0;
			out_low_q  <= S32_MIN;
			out_high_q <= S32_MAX;
			err_low_q  <= S32_MIN;
			err_high_q <= S32_MAX;
			prev_err_q <= '0;
			integ_q    <= '0;
			prevu_q    <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_GAIN_P:   gain_p_q   <= cfg_data;
					REG_GAIN_I:   gain_i_q   <= cfg_data;
					REG_GAIN_D:   gain_d_q   <= cfg_data;
					REG_GAIN_FF:  gain_ff_q  <= cfg_data;
					REG_OUT_LOW:  out_low_q  <= cfg_data;
					REG_OUT_HIGH: out_high_q <= cfg_data;
					REG_ERR_LOW:  err_low_q  <= cfg_data;
					REG_ERR_HIGH: err_high_q <= cfg_data;
					default:      gain_p_q   <= gain_p_q;
				endcase
			end
			if (cmd.integ) begin
				if ((&isum[ACC_W+1:ACC_W-1]) || !(|isum[ACC_W+1:ACC_W-1])) begin
					integ_q <= isum[ACC_W-1:0];
				end else begin
					integ_q <= isum[ACC_W+1] ? ACC_MIN : ACC_MAX;
				end
			end
			if (cmd.sum2) begin
				prev_err_q <= err_q;
				if ((&tot[ACC_W+1:UNC_W-1]) || !(|tot[ACC_W+1:UNC_W-1])) begin
					prevu_q <= tot[UNC_W-1:0];
				end else begin
					prevu_q <= tot[ACC_W+1] ? UNC_MIN : UNC_MAX;
				end
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			tgt_q  <= target;
			meas_q <= measured;
			dt_q   <= step_time;
			exp_q  <= expected;
			ff_q   <= ff_enable;
			mode_q <= mode;
		end
		if (cmd.calc_err) begin
			err_q      <= err_sat;
			ediff_q    <= ediff_wide;
			clipdiff_q <= {clip_v[UNC_W-1], clip_v} - {prevu_q[UNC_W-1], prevu_q};
			above_q    <= (prevu_q > hi_ext);
			below_q    <= (prevu_q < lo_ext);
		end
		if (cmd.prep) begin
			beta_q  <= (err_q >= err_low_q) && (err_q <= err_high_q);
			dneg_q  <= ddiff[DATA_W];
			if (above_q) begin
				gamma_q <= err_q[DATA_W-1];
			end else if (below_q) begin
				gamma_q <= !err_q[DATA_W-1] && (err_q != '0);
			end else begin
				gamma_q <= 1'b1;
			end
		end
		if (cmd.mul_load) begin
			amag_q <= a_mag;
			bmag_q <= b_mag;
			neg_q  <= a_sel[DATA_W-1] ^ b_neg;
		end
		if (cmd.mul_lo) begin
			plo_q <= mprod;
		end
		if (cmd.mul_hi) begin
			phi_q <= mprod;
		end
		if (cmd.mul_add) begin
			prod_q <= {phi_q, {HALF_W{1'b0}}} + PROD_W'(plo_q);
		end
		if (cmd.mul_fin) begin
			case (cmd.mul_op)
				MOP_ED:  incr1_q <= mres;
				MOP_AW:  incr2_q <= mres;
				MOP_P:   p_q     <= mres;
				MOP_I:   i_q     <= mres;
				MOP_F:   f_q     <= mres;
				MOP_D:   d_q     <= mres;
				default: d_q     <= mres;
			endcase
		end
		if (cmd.incr) begin
			if (mode_q) begin
				incr_q <= {incr1_q[ACC_W-1], incr1_q} + {incr2_q[ACC_W-1], incr2_q};
			end else if (beta_q && gamma_q) begin
				incr_q <= {incr1_q[ACC_W-1], incr1_q};
			end else begin
				incr_q <= '0;
			end
		end
		if (cmd.sum1) begin
			s1_q <= {p_q[ACC_W-1], p_q}
				+ (beta_q ? {i_q[ACC_W-1], i_q} : {(ACC_W+1){1'b0}});
			s2_q <= {d_q[ACC_W-1], d_q}
				+ (ff_q ? {f_q[ACC_W-1], f_q} : {(ACC_W+1){1'b0}});
		end
		if (cmd.out_load) begin
			drive_q <= clip_v[DATA_W-1:0];
		end
	end

`ifndef SYNTHESIS
	a_drive_in_limits: assert property (@(posedge clk) disable iff (!arst_n)
		($past(cmd.out_load) && $past(out_low_q <= out_high_q))
		|-> (drive_q >= $past(out_low_q)) && (drive_q <= $past(out_high_q)))
		else $error("drive outside the output limits");
`endif

endmodule

### tb/sv/tb_top.sv
module tb_top;
	import pid_aw_pkg::*;

	// Anti-windup mode codes carried in the mode bit
	localparam logic MODE_COND     = 1'b0;
	localparam logic MODE_BACKCALC = 1'b1;

	localparam int     ONE            = 1 << FRAC_BITS;
	localparam int     IDLE_PCT       = 19;
	localparam int     HOLD_CYCLES    = 400;
	localparam int     SETTLE         = 45;
	localparam int     WATCHDOG_LIMIT = 3000;
	localparam int     PHASES         = 10;
	localparam int     PHASE_ITEMS    = 150;
	localparam int     SHOW_MAX       = 10;

	localparam longint I32_MAX = 64'sd2147483647;
	localparam longint I32_MIN = -I32_MAX - 1;
	localparam longint S48_MAX = (64'sd1 <<< (ACC_W - 1)) - 1;
	localparam longint S48_MIN = -S48_MAX - 1;
	localparam longint S34_MAX = (64'sd1 <<< (UNC_W - 1)) - 1;
	localparam longint S34_MIN = -S34_MAX - 1;

	localparam logic signed [DATA_W-1:0] W_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] W_MIN = 32'sh8000_0000;

	typedef struct {
		logic signed [DATA_W-1:0] target;
		logic signed [DATA_W-1:0] measured;
		logic        [DT_W-1:0]   step_time;
		logic signed [DATA_W-1:0] expected;
		logic                     ff_enable;
		logic                     mode;
	} sample_t;

	typedef enum int {
		SET_TYPICAL,
		SET_EXTREME,
		SET_CROSSED,
		SET_WILD,
		SET_TIGHT
	} setting_kind_t;

	logic clk = 1'b0;
	logic arst_n;

	pid_aw_in_if  samp_if ();
	pid_aw_out_if res_if ();
	pid_aw_cfg_if cfg_if ();

	pid_antiwindup_controller dut (
		.clk    (clk),
		.arst_n (arst_n),
		.samp   (samp_if),
		.res    (res_if),
		.cfg    (cfg_if)
	);

	// Shadow of the register file and the loop state
	logic signed [DATA_W-1:0] setting [0:(1 << CFG_IDX_W)-1];
	longint                   last_err  = 0;
	longint                   integ     = 0;
	longint                   last_unc  = 0;

	sample_t                  sample_q [$];
	logic signed [DATA_W-1:0] drive_q  [$];

	logic samp_fire   = 1'b0;
	logic cfg_fire    = 1'b0;
	logic calm        = 1'b0;
	logic squeeze_arm = 1'b0;
	logic squeeze_done = 1'b0;
	int   hold_left   = 0;

	int n_fed = 0, n_in = 0, n_out = 0, n_settings = 0;
	int n_backcalc = 0, n_zero_step = 0, n_clipped = 0;
	int errors = 0, shown = 0, quiet_cycles = 0;

	initial begin
		setting[REG_GAIN_P]   = '0;
		setting[REG_GAIN_I]   = '0;
		setting[REG_GAIN_D]   = '0;
		setting[REG_GAIN_FF]  = '0;
		setting[REG_OUT_LOW]  = W_MIN;
		setting[REG_OUT_HIGH] = W_MAX;
		setting[REG_ERR_LOW]  = W_MIN;
		setting[REG_ERR_HIGH] = W_MAX;
	end

	// Clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint unsigned mag(longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic longint sat(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// Exact product, scaled down toward zero, held to 48 bits
	function automatic longint mul_q(longint a, longint b);
		logic [127:0] prod;
		logic [127:0] quo;
		logic         neg;
		neg  = (a < 0) != (b < 0);
		prod = {64'd0, mag(a)} * {64'd0, mag(b)};
		quo  = prod >> FRAC_BITS;
		if (quo > {64'd0, S48_MAX})
			return neg ? S48_MIN : S48_MAX;
		return neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
	endfunction

	// Raise to the low limit first, then lower to the high one
	function automatic longint clip_out(longint v);
		longint lo, hi;
		lo = setting[REG_OUT_LOW];
		hi = setting[REG_OUT_HIGH];
		if (v < lo)
			v = lo;
		if (v > hi)
			v = hi;
		return v;
	endfunction

	// Advance the loop state by one sample and return the drive it yields
	function automatic logic signed [DATA_W-1:0] predict_drive(sample_t s);
		longint          err, u, incr, dtv, diff, rate, tot, lim;
		longint          p_t, i_t, d_t, f_t, lo, hi, elo, ehi;
		longint unsigned quo;
		logic            in_win, may_int;
		lo  = setting[REG_OUT_LOW];
		hi  = setting[REG_OUT_HIGH];
		elo = setting[REG_ERR_LOW];
		ehi = setting[REG_ERR_HIGH];
		dtv = s.step_time;
		err = sat(longint'(s.target) - longint'(s.measured), I32_MIN, I32_MAX);
		in_win = (err >= elo) && (err <= ehi);
		u = last_unc;

		// Integrator update, gated or back-calculated
		if (s.mode == MODE_COND) begin
			if (u > hi)
				may_int = err < 0;
			else if (u < lo)
				may_int = err > 0;
			else
				may_int = 1'b1;
			incr = (in_win && may_int) ? mul_q(err, dtv) : 0;
		end else begin
			incr = mul_q(err, dtv) + mul_q(longint'(KAW_GAIN), clip_out(u) - u);
		end
		integ = sat(integ + incr, S48_MIN, S48_MAX);

		// Terms
		p_t = mul_q(setting[REG_GAIN_P], err);
		i_t = in_win ? mul_q(setting[REG_GAIN_I], integ) : 0;
		d_t = 0;
		if (dtv != 0) begin
			diff = err - last_err;
			quo  = (mag(diff) << DERIV_SHIFT) / longint'(dtv);
			rate = (diff < 0) ? -longint'(quo) : longint'(quo);
			d_t  = mul_q(setting[REG_GAIN_D], rate);
		end
		f_t = s.ff_enable ? mul_q(setting[REG_GAIN_FF],
			longint'(s.expected) - longint'(s.measured)) : 0;

		tot = sat(p_t + i_t + d_t + f_t, S34_MIN, S34_MAX);
		last_unc = tot;
		last_err = err;
		lim = clip_out(tot);
		if (lim != tot)
			n_clipped++;
		return DATA_W'(lim);
	endfunction

	function automatic int near_zero(int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic logic signed [DATA_W-1:0] rand_word();
		case ($urandom_range(7))
			0, 1: return $urandom;
			2: begin
				case ($urandom_range(4))
					0: return W_MIN;
					1: return W_MAX;
					2: return '0;
					3: return -1;
					default: return 1;
				endcase
			end
			default: return near_zero(200 * ONE);
		endcase
	endfunction

	function automatic logic [DT_W-1:0] rand_step();
		case ($urandom_range(9))
			0: return '0;
			1: return DT_W'($urandom);
			2: return '1;
			default: return DT_W'($urandom_range(64, 6554));
		endcase
	endfunction

	function automatic sample_t smp(logic signed [DATA_W-1:0] t, logic signed [DATA_W-1:0] m,
			logic [DT_W-1:0] dt, logic signed [DATA_W-1:0] e, logic ff, logic md);
		sample_t s;
		s.target    = t;
		s.measured  = m;
		s.step_time = dt;
		s.expected  = e;
		s.ff_enable = ff;
		s.mode      = md;
		return s;
	endfunction

	task automatic feed(sample_t s);
		sample_q.push_back(s);
		n_fed++;
	endtask

	// Mostly tracking sequences toward a held setpoint, the rest raw noise
	task automatic queue_random(int count);
		int      sp, plant;
		logic    md;
		sample_t s;
		sp    = 0;
		plant = 0;
		md    = 1'($urandom_range(1));
		repeat (count) begin
			if ($urandom_range(99) < 75) begin
				if ($urandom_range(19) == 0)
					sp = near_zero(150 * ONE);
				plant = plant + (sp - plant) / 8 + near_zero(ONE / 4);
				if ($urandom_range(29) == 0)
					md = ~md;
				s = smp(sp, plant, rand_step(), sp + near_zero(ONE),
					$urandom_range(3) != 0, md);
			end else begin
				s = smp(rand_word(), rand_word(), rand_step(), rand_word(),
					1'($urandom_range(1)), 1'($urandom_range(1)));
			end
			feed(s);
		end
	endtask

	// Called at a falling edge; leaves the channel at the falling edge after its beat
	task automatic cfg_write(cfg_reg_t idx, logic [DATA_W-1:0] val);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= val;
		do @(negedge clk); while (!cfg_fire);
	endtask

	task automatic apply_setting(logic signed [DATA_W-1:0] gp, logic signed [DATA_W-1:0] gi,
			logic signed [DATA_W-1:0] gd, logic signed [DATA_W-1:0] gf,
			logic signed [DATA_W-1:0] olo, logic signed [DATA_W-1:0] ohi,
			logic signed [DATA_W-1:0] elo, logic signed [DATA_W-1:0] ehi);
		cfg_write(REG_GAIN_P, gp);
		cfg_write(REG_GAIN_I, gi);
		cfg_write(REG_GAIN_D, gd);
		cfg_write(REG_GAIN_FF, gf);
		cfg_write(REG_OUT_LOW, olo);
		cfg_write(REG_OUT_HIGH, ohi);
		cfg_write(REG_ERR_LOW, elo);
		cfg_write(REG_ERR_HIGH, ehi);
		cfg_if.valid <= 1'b0;
		n_settings++;
		@(posedge clk);
	endtask

	// Wait until every fed sample has produced its result, then let the pipe empty
	task automatic drain();
		do @(negedge clk); while (n_in != n_fed || n_out != n_in);
		repeat (SETTLE) @(negedge clk);
	endtask

	// Sample driver: hold an unaccepted beat, else offer the next pending one
	always @(negedge clk) begin : drv
		sample_t nxt;
		if (arst_n && !(samp_if.valid && !samp_fire)) begin
			if (sample_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
				nxt = sample_q.pop_front();
				samp_if.target    <= nxt.target;
				samp_if.measured  <= nxt.measured;
				samp_if.step_time <= nxt.step_time;
				samp_if.expected  <= nxt.expected;
				samp_if.ff_enable <= nxt.ff_enable;
				samp_if.mode      <= nxt.mode;
				samp_if.valid     <= 1'b1;
			end else begin
				samp_if.valid <= 1'b0;
			end
		end
	end

	// Result acceptor: random stalls, one long hold-off when armed
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				res_if.ready <= 1'b0;
				hold_left    <= hold_left - 1;
			end else if (squeeze_arm && !squeeze_done) begin
				res_if.ready <= 1'b0;
				hold_left    <= HOLD_CYCLES;
				squeeze_done <= 1'b1;
			end else begin
				res_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Monitor: shadow register writes, check results, predict accepted samples
	always @(posedge clk) begin : mon
		sample_t                  got;
		logic signed [DATA_W-1:0] want;
		samp_fire <= samp_if.valid && samp_if.ready;
		cfg_fire  <= cfg_if.valid && cfg_if.ready;
		if (arst_n) begin
			if (cfg_if.valid && cfg_if.ready)
				setting[cfg_if.index] = cfg_if.data;

			if (res_if.valid && res_if.ready) begin
				n_out++;
				if (drive_q.size() == 0) begin
					errors++;
					if (shown < SHOW_MAX)
						$display("unexpected drive 0x%08h with no sample pending", res_if.drive);
					shown++;
				end else begin
					want = drive_q.pop_front();
					if (res_if.drive !== want) begin
						errors++;
						if (shown < SHOW_MAX)
							$display("drive mismatch on result %0d: expected %0d (0x%08h) got %0d (0x%08h)",
								n_out, want, want, res_if.drive, res_if.drive);
						shown++;
					end
				end
			end

			if (samp_if.valid && samp_if.ready) begin
				got.target    = samp_if.target;
				got.measured  = samp_if.measured;
				got.step_time = samp_if.step_time;
				got.expected  = samp_if.expected;
				got.ff_enable = samp_if.ff_enable;
				got.mode      = samp_if.mode;
				if (got.mode == MODE_BACKCALC)
					n_backcalc++;
				if (got.step_time == '0)
					n_zero_step++;
				drive_q.push_back(predict_drive(got));
				n_in++;
			end
		end
	end

	// Watchdog on cycles with no beat on any channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((samp_if.valid && samp_if.ready) || (res_if.valid && res_if.ready) ||
					(cfg_if.valid && cfg_if.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no beat for %0d cycles", quiet_cycles);
				$display("tb_top: errors");
				$finish;
			end
		end
	end

	// Stimulus sequence
	initial begin
		setting_kind_t kind;
		int            lim, win;
		arst_n            = 1'b0;
		samp_if.valid     = 1'b0;
		samp_if.target    = '0;
		samp_if.measured  = '0;
		samp_if.step_time = '0;
		samp_if.expected  = '0;
		samp_if.ff_enable = 1'b0;
		samp_if.mode      = MODE_COND;
		res_if.ready      = 1'b0;
		cfg_if.valid      = 1'b0;
		cfg_if.index      = REG_GAIN_P;
		cfg_if.data       = '0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// Reset values: all gains zero
		@(posedge clk);
		queue_random(4);
		drain();

		// Directed: windup in both directions under moderate gains
		apply_setting(ONE, ONE / 2, ONE / 100, ONE / 4, -100 * ONE, 100 * ONE,
			-50 * ONE, 50 * ONE);
		feed(smp(0, 0, '0, 0, 1'b0, MODE_COND));
		feed(smp(W_MAX, W_MIN, '1, W_MAX, 1'b1, MODE_COND));
		feed(smp(W_MIN, W_MAX, 16'd1, W_MIN, 1'b1, MODE_BACKCALC));
		repeat (4)
			feed(smp(40 * ONE, 0, 16'h8000, 40 * ONE, 1'b0, MODE_COND));
		feed(smp(90 * ONE, 0, 16'h8000, 0, 1'b0, MODE_COND));
		feed(smp(95 * ONE, 0, 16'h8000, 0, 1'b0, MODE_COND));
		feed(smp(0, 20 * ONE, 16'h8000, 0, 1'b0, MODE_COND));
		feed(smp(-150 * ONE, 0, 16'h8000, 0, 1'b0, MODE_COND));
		feed(smp(-150 * ONE, 0, 16'h8000, 0, 1'b0, MODE_COND));
		feed(smp(10 * ONE, 0, 16'h8000, 0, 1'b0, MODE_COND));
		feed(smp(-150 * ONE, 0, 16'h8000, 0, 1'b0, MODE_BACKCALC));
		feed(smp(-150 * ONE, 0, 16'h8000, 0, 1'b0, MODE_BACKCALC));
		feed(smp(30 * ONE, 0, '1, 0, 1'b1, MODE_BACKCALC));
		feed(smp(0, W_MIN, 16'd1, W_MAX, 1'b1, MODE_COND));
		feed(smp(0, 0, 16'd1, 0, 1'b0, MODE_COND));
		drain();

		// Directed: crossed output limits, empty error window, extreme gains
		apply_setting(W_MAX, W_MAX, W_MIN, W_MAX, 50 * ONE, -50 * ONE, 50 * ONE, -50 * ONE);
		feed(smp(ONE, 0, 16'h0100, ONE, 1'b1, MODE_COND));
		feed(smp(-ONE, 0, 16'h0100, 0, 1'b0, MODE_COND));
		feed(smp(ONE, 0, 16'h0100, 0, 1'b0, MODE_BACKCALC));
		feed(smp(W_MAX, W_MIN, '0, W_MIN, 1'b1, MODE_BACKCALC));
		drain();

		// Random phases, one register setting each
		for (int ph = 0; ph < PHASES; ph++) begin
			kind = setting_kind_t'(ph % 5);
			lim  = $urandom_range(ONE, 200 * ONE);
			win  = $urandom_range(ONE, 100 * ONE);
			case (kind)
				SET_TYPICAL:
					apply_setting(near_zero(4 * ONE), near_zero(2 * ONE), near_zero(ONE / 2),
						near_zero(ONE), -lim, lim, -win, win);
				SET_EXTREME:
					if (ph < 5)
						apply_setting(W_MAX, W_MAX, W_MAX, W_MAX, W_MIN, W_MAX, W_MIN, W_MAX);
					else
						apply_setting(W_MIN, W_MIN, W_MIN, W_MIN, 0, 0, 0, 0);
				SET_CROSSED:
					if (ph < 5)
						apply_setting(near_zero(4 * ONE), near_zero(2 * ONE), near_zero(ONE / 2),
							near_zero(ONE), lim, -lim, -win, win);
					else
						apply_setting(near_zero(4 * ONE), near_zero(2 * ONE), near_zero(ONE / 2),
							near_zero(ONE), lim, -lim, win, -win);
				SET_WILD:
					apply_setting($urandom, $urandom, $urandom, $urandom,
						$urandom, $urandom, $urandom, $urandom);
				default:
					apply_setting(near_zero(ONE), near_zero(ONE), near_zero(ONE / 8),
						near_zero(ONE), -10 * ONE, 10 * ONE, -5 * ONE, 5 * ONE);
			endcase
			calm        = (ph == 3);
			squeeze_arm = (ph == 6);
			queue_random(PHASE_ITEMS);
			drain();
		end

		if (drive_q.size() != 0) begin
			$display("%0d expected drive values never arrived", drive_q.size());
			errors += drive_q.size();
		end
		$display("run covered %0d samples under %0d register settings, %0d back-calculation, %0d zero step",
			n_in, n_settings, n_backcalc, n_zero_step);
		$display("%0d results checked, %0d clipped at an output limit, %0d failures",
			n_out, n_clipped, errors);
		if (errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
